### src/fbf_pkg.sv
// Shared types and constants for the fractional box filter line block.
// No dependencies; top, lane, merge and testbench refer to it by scoped names.
package fbf_pkg;

   localparam int SUM_W     = 23;
   localparam int WGT_W     = 17;
   localparam int FRAC_W    = 16;
   localparam int SPAN_CFG_W  = 7;
   localparam int OFF_CFG_W   = 6;
   localparam int PRIME_W   = 7;
   localparam int CLAMP_W   = 9;
   localparam int ROUND_HALF = 32768;

   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_SPAN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_WEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WEIGHT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WEIGHT = 3'd5;

   localparam logic [SPAN_CFG_W-1:0] SPAN_RESET   = 7'd2;
   localparam logic [OFF_CFG_W-1:0]  OFFSET_RESET = 6'd1;
   localparam logic [PRIME_W-1:0]    PRIME_RESET  = 7'd3;
   localparam logic [WGT_W-1:0]      SUM_WEIGHT_RESET   = 17'd21845;
   localparam logic [WGT_W-1:0]      LEFT_WEIGHT_RESET  = 17'd0;
   localparam logic [WGT_W-1:0]      RIGHT_WEIGHT_RESET = 17'd0;

   typedef enum logic [1:0] {
      LEFT_MEM,
      LEFT_FIRST,
      LEFT_CUR
   } left_src_type;

   typedef enum logic [1:0] {
      OUT_FILT,
      OUT_COPY,
      OUT_ZERO
   } out_kind_type;

   typedef struct packed {
      logic         emit;
      logic         done;
      out_kind_type kind;
   } out_ctl_type;

   typedef struct packed {
      logic         live;
      logic         first;
      left_src_type left_src;
      out_ctl_type  oc;
   } pipe_ctl_type;

   typedef struct packed {
      logic         adv2;
      logic         adv3;
      logic         live;
      logic         first;
      left_src_type left_src;
   } lane_ctl_type;

endpackage

### src/fbf_req_if.sv
// Input channel of the box filter: one four-channel pixel per item.
// Depends on nothing; used by the top level.
interface fbf_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_c0;
   logic [SAMPLE_BITS-1:0] sample_c1;
   logic [SAMPLE_BITS-1:0] sample_c2;
   logic [SAMPLE_BITS-1:0] sample_c3;
   logic                   row_end;

   modport source (
      output valid, sample_c0, sample_c1, sample_c2, sample_c3, row_end,
      input  ready
   );
   modport sink (
      input  valid, sample_c0, sample_c1, sample_c2, sample_c3, row_end,
      output ready
   );
endinterface

### src/fbf_rsp_if.sv
// Result channel of the box filter: one filtered pixel and its position per item.
// Depends on nothing; used by the merge stage and the top level.
interface fbf_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] result_c0;
   logic [SAMPLE_BITS-1:0] result_c1;
   logic [SAMPLE_BITS-1:0] result_c2;
   logic [SAMPLE_BITS-1:0] result_c3;
   logic [POS_BITS-1:0]    out_position;
   logic                   row_done;

   modport source (
      output valid, result_c0, result_c1, result_c2, result_c3, out_position, row_done,
      input  ready
   );
   modport sink (
      input  valid, result_c0, result_c1, result_c2, result_c3, out_position, row_done,
      output ready
   );
endinterface

### src/fractional_box_filter_line_top.sv
// Top level of the fractional box filter line: registers, delay memory, tail sequencer
// and stage control around the lanes and the merge stage. Depends on fbf_pkg, the
// channel interfaces, fbf_lane and fbf_merge.
//
//   Channel   Direction  Handshake           Content
//   req_chan  in         valid/ready         one pixel of four channels, row_end
//   rsp_chan  out        valid/ready         filtered pixel, position, row_done
//   csr_*     in         csr_we, no wait     register index and write data
//
// One pixel item is taken per cycle unless stalled or held; results pass the ctl1, ctl2,
// ctl3 and merge output registers. The pixel that ends a row holds the input while
// min(box_offset, row length) tail results are read from the delay memory's second port.
// The running sums close their loop combinationally, so pixels follow back to back.
// Reset is synchronous; the delay memory is not cleared, as it is only read where written.
// Stalls on the result side fill the pipeline bubbles before the input is held.
module fractional_box_filter_line_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SPAN    = 64,
   parameter int LANE_COUNT  = 4,
   parameter int MAX_LINE    = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   fbf_req_if.sink                          req_chan,
   fbf_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [fbf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbf_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int POS_W  = $clog2(MAX_LINE);
   localparam int AW     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int WS     = ((AW > SPAN_W) ? AW : SPAN_W) + 1;
   localparam int CMP_W  = ((POS_W > fbf_pkg::CLAMP_W) ? POS_W : fbf_pkg::CLAMP_W) + 1;
   localparam int PIX_W  = LANE_COUNT * SAMPLE_BITS;
   localparam int PS_W   = fbf_pkg::SUM_W + fbf_pkg::WGT_W;
   localparam int PE_W   = SAMPLE_BITS + fbf_pkg::WGT_W;

   function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] base,
                                                input logic [SPAN_W-1:0] back);
      logic [WS-1:0] a_w;
      logic [WS-1:0] b_w;
      logic [WS-1:0] r;
      a_w = WS'(base);
      b_w = WS'(back);
      if (a_w >= b_w) begin
         r = a_w - b_w;
      end else begin
         r = a_w + WS'(MAX_SPAN) - b_w;
      end
      return AW'(r);
   endfunction

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
      return (ptr == AW'(MAX_SPAN - 1)) ? '0 : ptr + 1'b1;
   endfunction

   logic [fbf_pkg::SPAN_CFG_W-1:0] span_cfg_ff;
   logic [fbf_pkg::OFF_CFG_W-1:0]  off_cfg_ff;
   logic [fbf_pkg::PRIME_W-1:0]    prime_ff;
   logic [fbf_pkg::WGT_W-1:0]      wsum_ff;
   logic [fbf_pkg::WGT_W-1:0]      wleft_ff;
   logic [fbf_pkg::WGT_W-1:0]      wright_ff;

   logic [SPAN_W-1:0] span_c;
   logic [SPAN_W-1:0] off_c;
   logic [CMP_W-1:0]  x_w, span_w, off_w, start_w, xp1_w;

   logic accept, flush_step, end0;
   logic en1, en2, en3, s3_ready;
   logic v1_ff, v1_in, v2_ff, v3_ff;

   logic [POS_W-1:0] pixel_index_ff, pixel_index_in;
   logic [AW-1:0]    wptr_ff, wptr_in;

   logic             flush_active_ff, flush_active_in;
   logic [POS_W-1:0] flush_p_ff, flush_p_in;
   logic [POS_W-1:0] flush_last_ff, flush_last_in;
   logic [AW-1:0]    flush_slot_ff, flush_slot_in;
   logic             flush_done;

   fbf_pkg::pipe_ctl_type ent_ctl;
   logic [POS_W-1:0]      ent_pos;
   logic [AW-1:0]         addr_a, addr_b;

   logic [SAMPLE_BITS-1:0] in_lane [4];
   logic [PIX_W-1:0]       wdata;
   logic [PIX_W-1:0]       dmem [MAX_SPAN];
   logic [PIX_W-1:0]       rda_ff, rdb_ff;

   fbf_pkg::pipe_ctl_type  ctl1_ff;
   logic [POS_W-1:0]       pos1_ff;
   logic [SAMPLE_BITS-1:0] cur1_ff [LANE_COUNT];
   fbf_pkg::out_ctl_type   ctl2_ff, ctl3_ff;
   logic [POS_W-1:0]       pos2_ff, pos3_ff;
   logic [SAMPLE_BITS-1:0] copy2_ff [LANE_COUNT];
   logic [SAMPLE_BITS-1:0] copy3_ff [LANE_COUNT];

   fbf_pkg::lane_ctl_type  lane_ctl;
   logic [PS_W-1:0]        prod_sum   [LANE_COUNT];
   logic [PE_W-1:0]        prod_left  [LANE_COUNT];
   logic [PE_W-1:0]        prod_right [LANE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         span_cfg_ff <= fbf_pkg::SPAN_RESET;
         off_cfg_ff  <= fbf_pkg::OFFSET_RESET;
         prime_ff    <= fbf_pkg::PRIME_RESET;
         wsum_ff     <= fbf_pkg::SUM_WEIGHT_RESET;
         wleft_ff    <= fbf_pkg::LEFT_WEIGHT_RESET;
         wright_ff   <= fbf_pkg::RIGHT_WEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fbf_pkg::CSR_BOX_SPAN:     span_cfg_ff <= csr_wdata[fbf_pkg::SPAN_CFG_W-1:0];
            fbf_pkg::CSR_BOX_OFFSET:   off_cfg_ff  <= csr_wdata[fbf_pkg::OFF_CFG_W-1:0];
            fbf_pkg::CSR_PRIME_COUNT:  prime_ff    <= csr_wdata[fbf_pkg::PRIME_W-1:0];
            fbf_pkg::CSR_SUM_WEIGHT:   wsum_ff     <= csr_wdata;
            fbf_pkg::CSR_LEFT_WEIGHT:  wleft_ff    <= csr_wdata;
            fbf_pkg::CSR_RIGHT_WEIGHT: wright_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign span_c = (fbf_pkg::CLAMP_W'(span_cfg_ff) > fbf_pkg::CLAMP_W'(MAX_SPAN)) ?
                   SPAN_W'(MAX_SPAN) : SPAN_W'(span_cfg_ff);
   assign off_c  = (fbf_pkg::CLAMP_W'(off_cfg_ff) > fbf_pkg::CLAMP_W'(MAX_SPAN)) ?
                   SPAN_W'(MAX_SPAN) : SPAN_W'(off_cfg_ff);

   assign en3 = !v3_ff || s3_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_chan.ready = en1 && !flush_active_ff;
   assign accept         = req_chan.valid && req_chan.ready;
   assign flush_step     = en1 && flush_active_ff;
   assign end0           = req_chan.row_end || (pixel_index_ff == POS_W'(MAX_LINE - 1));
   assign flush_done     = (flush_p_ff == flush_last_ff);

   assign in_lane[0] = req_chan.sample_c0;
   assign in_lane[1] = req_chan.sample_c1;
   assign in_lane[2] = req_chan.sample_c2;
   assign in_lane[3] = req_chan.sample_c3;

   always_comb begin
      for (int l = 0; l < LANE_COUNT; l++) begin
         wdata[l*SAMPLE_BITS +: SAMPLE_BITS] = in_lane[l];
      end
   end

   always_comb begin
      x_w     = CMP_W'(pixel_index_ff);
      span_w  = CMP_W'(span_c);
      off_w   = CMP_W'(off_c);
      start_w = (span_w > off_w) ? span_w : off_w;
      xp1_w   = x_w + 1'b1;

      pixel_index_in  = pixel_index_ff;
      wptr_in         = wptr_ff;
      flush_active_in = flush_active_ff;
      flush_p_in      = flush_p_ff;
      flush_last_in   = flush_last_ff;
      flush_slot_in   = flush_slot_ff;

      if (flush_active_ff) begin
         ent_ctl.live     = 1'b0;
         ent_ctl.first    = 1'b0;
         ent_ctl.left_src = fbf_pkg::LEFT_CUR;
         ent_ctl.oc.emit  = 1'b1;
         ent_ctl.oc.done  = flush_done;
         ent_ctl.oc.kind  = (CMP_W'(flush_p_ff) < off_w) ? fbf_pkg::OUT_COPY
                                                         : fbf_pkg::OUT_ZERO;
         ent_pos = flush_p_ff;
         addr_a  = flush_slot_ff;
         addr_b  = flush_slot_ff;
      end else begin
         ent_ctl.live  = 1'b1;
         ent_ctl.first = (pixel_index_ff == '0);
         if (span_c == '0) begin
            ent_ctl.left_src = fbf_pkg::LEFT_CUR;
         end else if (span_w > x_w) begin
            ent_ctl.left_src = fbf_pkg::LEFT_FIRST;
         end else begin
            ent_ctl.left_src = fbf_pkg::LEFT_MEM;
         end
         ent_ctl.oc.emit = (x_w >= off_w);
         ent_ctl.oc.done = end0 && (off_c == '0);
         if (x_w >= start_w) begin
            ent_ctl.oc.kind = fbf_pkg::OUT_FILT;
         end else if ((x_w - off_w) < off_w) begin
            ent_ctl.oc.kind = fbf_pkg::OUT_COPY;
         end else begin
            ent_ctl.oc.kind = fbf_pkg::OUT_ZERO;
         end
         ent_pos = POS_W'(x_w - off_w);
         addr_a  = wrap_back(wptr_ff, span_c);
         addr_b  = wrap_back(wptr_ff, off_c);
      end

      if (accept) begin
         pixel_index_in = end0 ? '0 : pixel_index_ff + 1'b1;
         wptr_in        = end0 ? '0 : wrap_inc(wptr_ff);
         if (end0 && (off_c != '0)) begin
            flush_active_in = 1'b1;
            flush_last_in   = pixel_index_ff;
            if (xp1_w > off_w) begin
               flush_p_in    = POS_W'(xp1_w - off_w);
               flush_slot_in = wrap_back(wrap_inc(wptr_ff), off_c);
            end else begin
               flush_p_in    = '0;
               flush_slot_in = '0;
            end
         end
      end else if (flush_step) begin
         if (flush_done) begin
            flush_active_in = 1'b0;
         end else begin
            flush_p_in    = flush_p_ff + 1'b1;
            flush_slot_in = wrap_inc(flush_slot_ff);
         end
      end
   end

   assign v1_in = en1 ? (accept || flush_step) : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_index_ff  <= '0;
         wptr_ff         <= '0;
         flush_active_ff <= 1'b0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
      end else begin
         pixel_index_ff  <= pixel_index_in;
         wptr_ff         <= wptr_in;
         flush_active_ff <= flush_active_in;
         v1_ff           <= v1_in;
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      flush_p_ff    <= flush_p_in;
      flush_last_ff <= flush_last_in;
      flush_slot_ff <= flush_slot_in;
   end

   // Read-first: a read of the slot being written returns the pixel one span back.
   always_ff @(posedge clock) begin
      if (accept) begin
         dmem[wptr_ff] <= wdata;
      end
      if (en1) begin
         rda_ff <= dmem[addr_a];
         rdb_ff <= dmem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ctl1_ff <= ent_ctl;
         pos1_ff <= ent_pos;
         for (int l = 0; l < LANE_COUNT; l++) begin
            cur1_ff[l] <= in_lane[l];
         end
      end
      if (en2) begin
         ctl2_ff <= ctl1_ff.oc;
         pos2_ff <= pos1_ff;
         for (int l = 0; l < LANE_COUNT; l++) begin
            copy2_ff[l] <= rdb_ff[l*SAMPLE_BITS +: SAMPLE_BITS];
         end
      end
      if (en3) begin
         ctl3_ff  <= ctl2_ff;
         pos3_ff  <= pos2_ff;
         copy3_ff <= copy2_ff;
      end
   end

   always_comb begin
      lane_ctl.adv2     = en2;
      lane_ctl.adv3     = en3;
      lane_ctl.live     = v1_ff && ctl1_ff.live;
      lane_ctl.first    = ctl1_ff.first;
      lane_ctl.left_src = ctl1_ff.left_src;
   end

   for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
      fbf_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .cur          (cur1_ff[l]),
         .mem_left     (rda_ff[l*SAMPLE_BITS +: SAMPLE_BITS]),
         .prime_count  (prime_ff),
         .sum_weight   (wsum_ff),
         .left_weight  (wleft_ff),
         .right_weight (wright_ff),
         .prod_sum     (prod_sum[l]),
         .prod_left    (prod_left[l]),
         .prod_right   (prod_right[l])
      );
   end

   fbf_merge #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LANE_COUNT  (LANE_COUNT),
      .POS_BITS    (POS_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .s3_valid   (v3_ff),
      .s3_ctl     (ctl3_ff),
      .s3_pos     (pos3_ff),
      .copy_val   (copy3_ff),
      .prod_sum   (prod_sum),
      .prod_left  (prod_left),
      .prod_right (prod_right),
      .s3_ready   (s3_ready),
      .rsp        (rsp_chan)
   );

`ifndef SYNTHESIS
   a_tail_starts: assert property (@(posedge clock) disable iff (reset)
      accept && end0 && (off_c != '0) |=> flush_active_ff)
      else $error("Row end with a non-zero offset did not start the tail.");

   a_tail_bounded: assert property (@(posedge clock) disable iff (reset)
      flush_active_ff |-> (flush_p_ff <= flush_last_ff))
      else $error("Tail position ran past the last pixel of the row.");

   a_row_start_aligned: assert property (@(posedge clock) disable iff (reset)
      (pixel_index_ff == '0) |-> (wptr_ff == '0))
      else $error("Delay memory pointer out of step with the pixel index.");

   a_tail_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(flush_active_ff) |-> $past(accept && end0))
      else $error("Tail started without a row-ending item.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && ctl3_ff.emit && !s3_ready |=> v3_ff && $stable(pos3_ff))
      else $error("Result waiting at the merge stage was lost during a stall.");
`endif

endmodule

### src/fbf_lane.sv
// One channel lane: running window sum, edge selection and the three weighted products.
// Depends on fbf_pkg; instantiated once per lane by the top level.
module fbf_lane #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  fbf_pkg::lane_ctl_type                      ctl,
   input  logic [SAMPLE_BITS-1:0]                     cur,
   input  logic [SAMPLE_BITS-1:0]                     mem_left,
   input  logic [fbf_pkg::PRIME_W-1:0]                prime_count,
   input  logic [fbf_pkg::WGT_W-1:0]                  sum_weight,
   input  logic [fbf_pkg::WGT_W-1:0]                  left_weight,
   input  logic [fbf_pkg::WGT_W-1:0]                  right_weight,
   output logic [fbf_pkg::SUM_W+fbf_pkg::WGT_W-1:0]   prod_sum,
   output logic [SAMPLE_BITS+fbf_pkg::WGT_W-1:0]      prod_left,
   output logic [SAMPLE_BITS+fbf_pkg::WGT_W-1:0]      prod_right
);

   localparam int PRIME_PROD_W = SAMPLE_BITS + fbf_pkg::PRIME_W;
   localparam int PS_W = fbf_pkg::SUM_W + fbf_pkg::WGT_W;
   localparam int PE_W = SAMPLE_BITS + fbf_pkg::WGT_W;

   logic [fbf_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]    first_ff;
   logic [SAMPLE_BITS-1:0]    first_val;
   logic [SAMPLE_BITS-1:0]    left;
   logic [PRIME_PROD_W-1:0]   prime_prod;
   logic [fbf_pkg::SUM_W-1:0] base;
   logic [fbf_pkg::SUM_W-1:0] diff;

   logic [fbf_pkg::SUM_W-1:0] diff2_ff;
   logic [SAMPLE_BITS-1:0]    left2_ff;
   logic [SAMPLE_BITS-1:0]    cur2_ff;

   logic [PS_W-1:0] prod_sum_ff;
   logic [PE_W-1:0] prod_left_ff;
   logic [PE_W-1:0] prod_right_ff;

   always_comb begin
      first_val = ctl.first ? cur : first_ff;
      case (ctl.left_src)
         fbf_pkg::LEFT_CUR:   left = cur;
         fbf_pkg::LEFT_FIRST: left = first_val;
         default:             left = mem_left;
      endcase
      prime_prod = PRIME_PROD_W'(cur) * PRIME_PROD_W'(prime_count);
      base       = ctl.first ? fbf_pkg::SUM_W'(prime_prod) : sum_ff;
      diff       = base - fbf_pkg::SUM_W'(left);
      sum_in     = diff + fbf_pkg::SUM_W'(cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         first_ff <= '0;
      end else if (ctl.adv2 && ctl.live) begin
         sum_ff <= sum_in;
         if (ctl.first) begin
            first_ff <= cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv2) begin
         diff2_ff <= diff;
         left2_ff <= left;
         cur2_ff  <= cur;
      end
      if (ctl.adv3) begin
         prod_sum_ff   <= PS_W'(diff2_ff) * PS_W'(sum_weight);
         prod_left_ff  <= PE_W'(left2_ff) * PE_W'(left_weight);
         prod_right_ff <= PE_W'(cur2_ff) * PE_W'(right_weight);
      end
   end

   assign prod_sum   = prod_sum_ff;
   assign prod_left  = prod_left_ff;
   assign prod_right = prod_right_ff;

endmodule

### src/fbf_merge.sv
// Merge stage: adds, rounds and saturates each lane, selects filtered, copied or zero
// values and holds the result item in the output register. Depends on fbf_pkg, fbf_rsp_if.
module fbf_merge #(
   parameter int SAMPLE_BITS = 16,
   parameter int LANE_COUNT  = 4,
   parameter int POS_BITS    = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     s3_valid,
   input  fbf_pkg::out_ctl_type                     s3_ctl,
   input  logic [POS_BITS-1:0]                      s3_pos,
   input  logic [SAMPLE_BITS-1:0]                   copy_val   [LANE_COUNT],
   input  logic [fbf_pkg::SUM_W+fbf_pkg::WGT_W-1:0] prod_sum   [LANE_COUNT],
   input  logic [SAMPLE_BITS+fbf_pkg::WGT_W-1:0]    prod_left  [LANE_COUNT],
   input  logic [SAMPLE_BITS+fbf_pkg::WGT_W-1:0]    prod_right [LANE_COUNT],
   output logic                                     s3_ready,
   fbf_rsp_if.source                                rsp
);

   localparam int PS_W  = fbf_pkg::SUM_W + fbf_pkg::WGT_W;
   localparam int PE_W  = SAMPLE_BITS + fbf_pkg::WGT_W;
   localparam int ACC_W = ((PS_W > PE_W) ? PS_W : PE_W) + 2;
   localparam int TOP_B = fbf_pkg::FRAC_W + SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0] res_in [4];
   logic [SAMPLE_BITS-1:0] res_ff [4];
   logic [POS_BITS-1:0]    pos_ff;
   logic                   done_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   load;

   for (genvar l = 0; l < 4; l++) begin : g_lane
      if (l < LANE_COUNT) begin : g_used
         logic [ACC_W-1:0]       acc;
         logic                   sat;
         logic [SAMPLE_BITS-1:0] filt;
         assign acc  = ACC_W'(prod_sum[l]) + ACC_W'(prod_left[l]) + ACC_W'(prod_right[l])
                       + ACC_W'(fbf_pkg::ROUND_HALF);
         assign sat  = |acc[ACC_W-1:TOP_B];
         assign filt = sat ? '1 : acc[TOP_B-1:fbf_pkg::FRAC_W];
         assign res_in[l] = (s3_ctl.kind == fbf_pkg::OUT_FILT) ? filt :
                            (s3_ctl.kind == fbf_pkg::OUT_COPY) ? copy_val[l] : '0;
      end else begin : g_unused
         assign res_in[l] = '0;
      end
   end

   assign s3_ready     = !s3_ctl.emit || !out_valid_ff || rsp.ready;
   assign load         = s3_valid && s3_ctl.emit && s3_ready;
   assign out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= res_in;
         pos_ff  <= s3_pos;
         done_ff <= s3_ctl.done;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_c0    = res_ff[0];
   assign rsp.result_c1    = res_ff[1];
   assign rsp.result_c2    = res_ff[2];
   assign rsp.result_c3    = res_ff[3];
   assign rsp.out_position = pos_ff;
   assign rsp.row_done     = done_ff;

endmodule

### tb/fractional_box_filter_line_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fractional box filter line block: drives pixel lines
// under varied register settings and compares every result with its own line model.
// Depends on fbf_pkg, the two channel interfaces and fractional_box_filter_line_top.
module fractional_box_filter_line_top_test;

   localparam int unsigned MAX_SPAN    = 64;
   localparam int unsigned MAX_LINE    = 4096;
   localparam int unsigned LANES       = 4;
   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned LONG_LINE   = 120;

   typedef struct packed {
      logic             row_end;
      logic [3:0][15:0] sample;
   } pixel_item_type;

   typedef struct packed {
      logic [3:0][15:0] value;
      logic [11:0]      position;
      logic             row_done;
   } filtered_item_type;

   typedef enum {FILL_RANDOM, FILL_PATTERN, FILL_FLAT, FILL_FULL} fill_type;
   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [fbf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [fbf_pkg::CSR_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   pixel_item_type req_pixel = '0;
   logic rsp_ready = 1'b0;

   fbf_req_if #(.SAMPLE_BITS(16)) req_chan ();
   fbf_rsp_if #(.SAMPLE_BITS(16), .POS_BITS(12)) rsp_chan ();

   assign req_chan.valid     = req_valid;
   assign req_chan.sample_c0 = req_pixel.sample[0];
   assign req_chan.sample_c1 = req_pixel.sample[1];
   assign req_chan.sample_c2 = req_pixel.sample[2];
   assign req_chan.sample_c3 = req_pixel.sample[3];
   assign req_chan.row_end   = req_pixel.row_end;
   assign rsp_chan.ready     = rsp_ready;

   fractional_box_filter_line_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Line model state and its copy of the registers.
   int unsigned span_cfg   = fbf_pkg::SPAN_RESET;
   int unsigned offset_cfg = fbf_pkg::OFFSET_RESET;
   int unsigned prime_cfg  = fbf_pkg::PRIME_RESET;
   int unsigned w_sum      = fbf_pkg::SUM_WEIGHT_RESET;
   int unsigned w_left     = fbf_pkg::LEFT_WEIGHT_RESET;
   int unsigned w_right    = fbf_pkg::RIGHT_WEIGHT_RESET;
   logic [3:0][15:0] line_store [MAX_SPAN];
   logic [22:0] run_sum [LANES] = '{default: '0};
   logic [3:0][15:0] line_first = '0;
   int unsigned line_x = 0;

   pixel_item_type pixel_q [$];
   filtered_item_type due_results [$];
   filtered_item_type got, want;

   int unsigned pixels_offered = 0, pixels_taken = 0, results_checked = 0, mismatches = 0;
   int unsigned cycle_count = 0, lines_queued = 0, random_pixels = 0, settings_applied = 1;
   int unsigned gap_left = 0, burst_left = 1, rx_tick = 0, hold_mark = 0;
   bit result_hold = 1'b0;
   rx_style_type rx_style = RX_OPEN;

   function automatic logic [3:0][15:0] tap_pixel(int unsigned x, int unsigned back,
                                                  logic [3:0][15:0] cur);
      if (back == 0) return cur;
      if (back > x) return line_first;
      return line_store[(x - back) % MAX_SPAN];
   endfunction

   function automatic logic [3:0][15:0] copy_pixel(int unsigned x, int unsigned p,
                                                   logic [3:0][15:0] cur, int unsigned off);
      if (p < off) return tap_pixel(x, x - p, cur);
      return '0;
   endfunction

   function automatic void owe_result(logic [3:0][15:0] value, int unsigned pos, bit done);
      filtered_item_type item;
      item.value    = value;
      item.position = 12'(pos);
      item.row_done = done;
      due_results.push_back(item);
   endfunction

   task automatic filter_pixel(pixel_item_type px);
      int unsigned x, span, off, start, p;
      int l;
      bit ending;
      logic [3:0][15:0] filt, left_px;
      logic [63:0] acc;
      x = line_x;
      span = (span_cfg > MAX_SPAN) ? MAX_SPAN : span_cfg;
      off = (offset_cfg > MAX_SPAN) ? MAX_SPAN : offset_cfg;
      start = (span > off) ? span : off;
      ending = px.row_end || (x >= MAX_LINE - 1);
      if (x == 0) begin
         line_first = px.sample;
         for (l = 0; l < LANES; l++) run_sum[l] = 23'(prime_cfg * px.sample[l]);
      end
      left_px = tap_pixel(x, span, px.sample);
      for (l = 0; l < LANES; l++) begin
         run_sum[l] = run_sum[l] - 23'(left_px[l]);
         acc = 64'(run_sum[l]) * w_sum + 64'(left_px[l]) * w_left
             + 64'(px.sample[l]) * w_right + 64'(fbf_pkg::ROUND_HALF);
         acc = acc >> fbf_pkg::FRAC_W;
         filt[l] = (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
         run_sum[l] = run_sum[l] + 23'(px.sample[l]);
      end
      if (x >= off) begin
         p = x - off;
         owe_result((x >= start) ? filt : copy_pixel(x, p, px.sample, off), p,
                    ending && off == 0);
      end
      if (ending) begin
         for (p = (x + 1 > off) ? x + 1 - off : 0; p <= x; p++) begin
            owe_result(copy_pixel(x, p, px.sample, off), p, p == x);
         end
      end
      line_store[x % MAX_SPAN] = px.sample;
      line_x = ending ? 0 : x + 1;
   endtask

   // Result checking and pixel acceptance, both sampled at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, due_results.size());
         $display("FAIL");
         $finish;
      end else if (!reset) begin
         if (rsp_chan.valid && rsp_ready) begin
            got.value = {rsp_chan.result_c3, rsp_chan.result_c2,
                         rsp_chan.result_c1, rsp_chan.result_c0};
            got.position = rsp_chan.out_position;
            got.row_done = rsp_chan.row_done;
            results_checked++;
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result for position %0d at cycle %0d.",
                           got.position, cycle_count);
            end else begin
               want = due_results.pop_front();
               if (got.value !== want.value || got.position !== want.position
                   || got.row_done !== want.row_done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %h %h %h %h pos %0d done %b,",
                              want.value[0], want.value[1], want.value[2], want.value[3],
                              want.position, want.row_done,
                              " got %h %h %h %h pos %0d done %b",
                              got.value[0], got.value[1], got.value[2], got.value[3],
                              got.position, got.row_done);
               end
            end
         end
         if (req_valid && req_chan.ready) begin
            filter_pixel(req_pixel);
            pixels_taken++;
         end
      end
   end

   // Pixel sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (pixels_offered == pixels_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_q.size() != 0) begin
            req_pixel <= pixel_q.pop_front();
            req_valid <= 1'b1;
            pixels_offered++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: drives ready with a stall pattern that is redrawn at random.
   always @(negedge clock) begin
      rx_tick++;
      if (rx_tick % 50 == 0) rx_style = rx_style_type'($urandom_range(0, 3));
      if (reset || result_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         case (rx_style)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= $urandom_range(0, 1) == 1;
            RX_SPARSE: rsp_ready <= (rx_tick % 4) == 0;
            default:   rsp_ready <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   // One long hold-off on the result side while pixels keep coming.
   initial begin
      wait (hold_mark != 0 && pixels_taken >= hold_mark);
      @(posedge clock);
      result_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      result_hold = 1'b0;
   end

   task automatic write_reg(logic [fbf_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= fbf_pkg::CSR_W'(value);
      case (idx)
         fbf_pkg::CSR_BOX_SPAN:     span_cfg   = value % (1 << fbf_pkg::SPAN_CFG_W);
         fbf_pkg::CSR_BOX_OFFSET:   offset_cfg = value % (1 << fbf_pkg::OFF_CFG_W);
         fbf_pkg::CSR_PRIME_COUNT:  prime_cfg  = value % (1 << fbf_pkg::PRIME_W);
         fbf_pkg::CSR_SUM_WEIGHT:   w_sum      = value % (1 << fbf_pkg::WGT_W);
         fbf_pkg::CSR_LEFT_WEIGHT:  w_left     = value % (1 << fbf_pkg::WGT_W);
         fbf_pkg::CSR_RIGHT_WEIGHT: w_right    = value % (1 << fbf_pkg::WGT_W);
         default: ;
      endcase
   endtask

   task automatic apply_setting(int unsigned span, int unsigned off, int unsigned prime,
                                int unsigned sw, int unsigned lw, int unsigned rw);
      write_reg(fbf_pkg::CSR_BOX_SPAN, span);
      write_reg(fbf_pkg::CSR_BOX_OFFSET, off);
      write_reg(fbf_pkg::CSR_PRIME_COUNT, prime);
      write_reg(fbf_pkg::CSR_SUM_WEIGHT, sw);
      write_reg(fbf_pkg::CSR_LEFT_WEIGHT, lw);
      write_reg(fbf_pkg::CSR_RIGHT_WEIGHT, rw);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   task automatic queue_line(int unsigned len, fill_type style, bit mark_end);
      pixel_item_type px;
      logic [15:0] flat;
      int unsigned i;
      int lane;
      flat = 16'($urandom);
      for (i = 0; i < len; i++) begin
         for (lane = 0; lane < LANES; lane++) begin
            case (style)
               FILL_FULL: px.sample[lane] = 16'hFFFF;
               FILL_FLAT: px.sample[lane] = flat;
               FILL_PATTERN: begin
                  case (i % 4)
                     0: px.sample[lane] = 16'h0000;
                     1: px.sample[lane] = 16'hFFFF;
                     2: px.sample[lane] = (lane % 2 == 1) ? 16'h5555 : 16'hAAAA;
                     default: px.sample[lane] = (lane % 2 == 1) ? 16'hAAAA : 16'h5555;
                  endcase
               end
               default: begin
                  case ($urandom_range(0, 9))
                     0: px.sample[lane] = 16'h0000;
                     1: px.sample[lane] = 16'hFFFF;
                     default: px.sample[lane] = 16'($urandom);
                  endcase
               end
            endcase
         end
         px.row_end = mark_end && (i == len - 1);
         pixel_q.push_back(px);
      end
      lines_queued++;
   endtask

   task automatic settle();
      while (pixel_q.size() != 0 || pixels_offered != pixels_taken || due_results.size() != 0)
         @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic int unsigned pick_weight(int unsigned eff_span);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65536;
         2: return 131071;
         3: return $urandom_range(0, 131071);
         default: return $urandom_range(0, 131072 / (eff_span + 2));
      endcase
   endfunction

   task automatic random_phase();
      int unsigned span, off, eff, start, len, n_lines, i;
      case ($urandom_range(0, 5))
         0: span = 0;
         1: span = MAX_SPAN;
         2: span = $urandom_range(MAX_SPAN + 1, 127);
         3: span = $urandom_range(0, MAX_SPAN);
         default: span = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 4))
         0: off = 0;
         1: off = 63;
         2: off = $urandom_range(0, 63);
         default: off = $urandom_range(0, 6);
      endcase
      eff = (span > MAX_SPAN) ? MAX_SPAN : span;
      start = (eff > off) ? eff : off;
      apply_setting(span, off,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                : eff + $urandom_range(0, 1),
                    pick_weight(eff), pick_weight(eff), pick_weight(eff));
      n_lines = $urandom_range(1, 4);
      for (i = 0; i < n_lines; i++) begin
         case ($urandom_range(0, 7))
            0: len = $urandom_range(1, 3);
            1: len = $urandom_range(start + 1, start + 40);
            default: len = $urandom_range(1, start + 12);
         endcase
         queue_line(len, fill_type'($urandom_range(0, 3)), 1'b1);
         random_pixels += len;
      end
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      queue_line(1, FILL_FULL, 1'b1);
      queue_line(3, FILL_PATTERN, 1'b1);
      settle();
      apply_setting(100, 63, 0, 131071, 131071, 65536);
      queue_line(5, FILL_PATTERN, 1'b1);
      settle();
      apply_setting(0, 0, 1, 65536, 0, 0);
      queue_line(4, FILL_PATTERN, 1'b1);
      settle();
      apply_setting(1, 2, 127, 131071, 131071, 131071);
      queue_line(6, FILL_FULL, 1'b1);
      settle();
      apply_setting(3, 0, 0, 256, 0, 0);
      queue_line(5, FILL_RANDOM, 1'b1);
      settle();

      while (random_pixels < 140) random_phase();

      // A long line, during which the result side holds off for a long stretch.
      apply_setting($urandom_range(1, 8), $urandom_range(0, 5), $urandom_range(1, 9),
                    pick_weight(8), pick_weight(8), pick_weight(8));
      hold_mark = pixels_taken + 20;
      queue_line(LONG_LINE, FILL_RANDOM, 1'b1);
      random_pixels += LONG_LINE;
      settle();

      while (random_pixels < 400) random_phase();

      $display("Covered %0d pixels in %0d lines under %0d register settings,",
               pixels_taken, lines_queued, settings_applied,
               " with one long hold-off on the result side.");
      $display("Checked %0d results, %0d of them wrong or unexpected.",
               results_checked, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### fractional_box_filter_line_top.f
src/fbf_pkg.sv
src/fbf_req_if.sv
src/fbf_rsp_if.sv
src/fbf_lane.sv
src/fbf_merge.sv
src/fractional_box_filter_line_top.sv
tb/fractional_box_filter_line_top_test.sv
